// ===== rtl/distance_vector_route_table_core_defines.svh =====
// assertion macros for the route table rtl
// expects clk and rst_n in the scope of each use
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_CORE_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define DVRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DVRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DVRT_ASSERT_IMP(lbl, ante, cons, msg)
`define DVRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/dvrt_pkg.sv =====
// types and codes shared by the route table rtl
// no dependencies
`timescale 1ns / 1ps
package dvrt_pkg;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  localparam logic [1:0] REG_OWN_KEY     = 2'd0;
  localparam logic [1:0] REG_OWN_ADDRESS = 2'd1;
  localparam logic [1:0] REG_OWN_PORT    = 2'd2;

  localparam logic [1:0] KIND_ADVERT = 2'd0;
  localparam logic [1:0] KIND_SWEEP  = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam logic [2:0] STAT_INSERTED  = 3'd0;
  localparam logic [2:0] STAT_UPDATED   = 3'd1;
  localparam logic [2:0] STAT_REFRESHED = 3'd2;
  localparam logic [2:0] STAT_FULL      = 3'd3;
  localparam logic [2:0] STAT_HIT       = 3'd4;
  localparam logic [2:0] STAT_MISS      = 3'd5;
  localparam logic [2:0] STAT_SWEPT     = 3'd6;

  localparam logic [7:0] HOPS_MAX = 8'd255;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] dest_key;
    logic [31:0] via_address;
    logic [15:0] via_port;
    logic [7:0]  advert_hops;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  slot;
    logic [31:0] hop_address;
    logic [15:0] hop_port;
    logic [7:0]  hops;
    logic [7:0]  removed_count;
  } out_item_t;

  typedef struct packed {
    logic [63:0] own_key;
    logic [31:0] own_address;
    logic [15:0] own_port;
  } own_cfg_t;

  typedef struct packed {
    logic        valid;
    logic        refreshed;
    logic [63:0] key;
    logic [31:0] hop_address;
    logic [15:0] hop_port;
    logic [7:0]  hops;
  } entry_t;

  // advertised count plus one, held at the maximum
  function automatic logic [7:0] sat_inc(input logic [7:0] h);
    return (h == HOPS_MAX) ? HOPS_MAX : h + 8'd1;
  endfunction

endpackage

// ===== rtl/dvrt_regs.sv =====
// configuration registers of the route table: own key, address and port
// depends on dvrt_pkg
`timescale 1ns / 1ps
module dvrt_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dvrt_pkg::CFG_AW-1:0] paddr,
  input  logic [dvrt_pkg::CFG_DW-1:0] pwdata,
  output logic [dvrt_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output dvrt_pkg::own_cfg_t          own_cfg
);
  import dvrt_pkg::*;

  logic [63:0] own_key_r;
  logic [31:0] own_address_r;
  logic [15:0] own_port_r;
  logic [1:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_key_r     <= '0;
      own_address_r <= '0;
      own_port_r    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_OWN_KEY:     own_key_r     <= pwdata;
        REG_OWN_ADDRESS: own_address_r <= pwdata[31:0];
        REG_OWN_PORT:    own_port_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_OWN_KEY:     prdata = own_key_r;
      REG_OWN_ADDRESS: prdata = {32'd0, own_address_r};
      REG_OWN_PORT:    prdata = {48'd0, own_port_r};
      default:         prdata = '0;
    endcase
  end

  assign own_cfg.own_key     = own_key_r;
  assign own_cfg.own_address = own_address_r;
  assign own_cfg.own_port    = own_port_r;

endmodule

// ===== rtl/distance_vector_route_table_core.sv =====
// Distance-vector route table. All slots live in one single-port-write,
// registered-read memory that is scanned one slot per cycle: an advert, a
// sweep or a lookup goes from acceptance through a read of every slot, a
// drain state for the last read data and a finish state that writes back
// an advert's entry and loads the output register, holding while it stalls.
// An advert or lookup for the node's own key skips the scan and goes to the
// finish state, and an item of the unused kind is dropped without a result.
// After reset a clearing pass marks every slot invalid; no request is
// accepted until it ends.
// depends on dvrt_pkg, dvrt_regs and the assertion macro header
`timescale 1ns / 1ps
`include "distance_vector_route_table_core_defines.svh"
module distance_vector_route_table_core #(
  parameter int ENTRIES = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  dvrt_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output dvrt_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dvrt_pkg::CFG_AW-1:0] paddr,
  input  logic [dvrt_pkg::CFG_DW-1:0] pwdata,
  output logic [dvrt_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import dvrt_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  own_cfg_t own_cfg;

  dvrt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .own_cfg (own_cfg)
  );

  entry_t mem [ENTRIES];

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] rd_addr_r, chk_addr_r;
  logic          rd_pend_r;
  entry_t        rd_data_r;
  in_item_t      req_r;
  logic          own_r;
  logic          found_r, free_r;
  logic [AW-1:0] found_slot_r, free_slot_r;
  entry_t        found_ent_r;
  logic [7:0]    removed_r;
  logic          out_valid_r;
  out_item_t     out_data_r;

  logic          accept, can_load, mem_re, mem_we;
  logic          hit_now, free_now, sweep_we, fin_we, better;
  logic [7:0]    new_hops;
  logic [AW-1:0] wr_addr;
  entry_t        wr_entry;
  out_item_t     res;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign can_load  = !out_valid_r || !out_stall;
  assign mem_re    = (state_r == S_SCAN);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // data stage: look at the slot read in the previous cycle
  assign hit_now  = rd_pend_r && rd_data_r.valid && (rd_data_r.key == req_r.dest_key)
                    && !found_r;
  assign free_now = rd_pend_r && !rd_data_r.valid && !free_r;
  assign sweep_we = rd_pend_r && (req_r.kind == KIND_SWEEP);
  assign fin_we   = (state_r == S_FINISH) && can_load && !own_r
                    && (req_r.kind == KIND_ADVERT) && (found_r || free_r);
  assign new_hops = sat_inc(req_r.advert_hops);
  assign better   = found_ent_r.hops > req_r.advert_hops;
  assign mem_we   = (state_r == S_CLEAR) || sweep_we || fin_we;

  always_comb begin
    wr_addr  = rd_addr_r;
    wr_entry = '0;
    if (sweep_we) begin
      // stale entries drop out, every mark is cleared
      wr_addr            = chk_addr_r;
      wr_entry           = rd_data_r;
      wr_entry.valid     = rd_data_r.valid && rd_data_r.refreshed;
      wr_entry.refreshed = 1'b0;
    end else if (fin_we && found_r) begin
      wr_addr            = found_slot_r;
      wr_entry           = found_ent_r;
      wr_entry.refreshed = 1'b1;
      if (better) begin
        wr_entry.hop_address = req_r.via_address;
        wr_entry.hop_port    = req_r.via_port;
        wr_entry.hops        = new_hops;
      end
    end else if (fin_we) begin
      wr_addr              = free_slot_r;
      wr_entry.valid       = 1'b1;
      wr_entry.refreshed   = 1'b1;
      wr_entry.key         = req_r.dest_key;
      wr_entry.hop_address = req_r.via_address;
      wr_entry.hop_port    = req_r.via_port;
      wr_entry.hops        = new_hops;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr_r];
    end
  end

  always_comb begin
    res = '0;
    case (req_r.kind)
      KIND_ADVERT: begin
        if (own_r) begin
          res.status = STAT_REFRESHED;
        end else if (found_r) begin
          res.status = better ? STAT_UPDATED : STAT_REFRESHED;
          res.slot   = 7'(found_slot_r);
          res.hops   = better ? new_hops : found_ent_r.hops;
        end else if (free_r) begin
          res.status = STAT_INSERTED;
          res.slot   = 7'(free_slot_r);
          res.hops   = new_hops;
        end else begin
          res.status = STAT_FULL;
        end
      end
      KIND_SWEEP: begin
        res.status        = STAT_SWEPT;
        res.removed_count = removed_r;
      end
      KIND_LOOKUP: begin
        if (own_r) begin
          res.status      = STAT_HIT;
          res.hop_address = own_cfg.own_address;
          res.hop_port    = own_cfg.own_port;
        end else if (found_r) begin
          res.status      = STAT_HIT;
          res.slot        = 7'(found_slot_r);
          res.hop_address = found_ent_r.hop_address;
          res.hop_port    = found_ent_r.hop_port;
          res.hops        = found_ent_r.hops;
        end else begin
          res.status = STAT_MISS;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (rd_addr_r == LAST) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept && (in_data.kind == KIND_ADVERT || in_data.kind == KIND_LOOKUP)
            && in_data.dest_key == own_cfg.own_key) begin
          state_nxt = S_FINISH;
        end else if (accept && (in_data.kind == KIND_ADVERT
                     || in_data.kind == KIND_LOOKUP || in_data.kind == KIND_SWEEP)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN:   if (rd_addr_r == LAST) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = S_FINISH;
      S_FINISH: if (can_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      rd_addr_r   <= '0;
      rd_pend_r   <= 1'b0;
      own_r       <= 1'b0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      removed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= mem_re;
      if (state_r == S_CLEAR || state_r == S_SCAN) begin
        rd_addr_r <= (rd_addr_r == LAST) ? '0 : rd_addr_r + AW'(1);
      end
      if (accept) begin
        own_r     <= (in_data.kind != KIND_SWEEP) && (in_data.dest_key == own_cfg.own_key);
        found_r   <= 1'b0;
        free_r    <= 1'b0;
        removed_r <= '0;
      end else begin
        if (hit_now) found_r <= 1'b1;
        if (free_now) free_r <= 1'b1;
        if (sweep_we && rd_data_r.valid && !rd_data_r.refreshed) begin
          removed_r <= removed_r + 8'd1;
        end
      end
      if (state_r == S_FINISH && can_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r <= rd_addr_r;
    if (accept) begin
      req_r <= in_data;
    end
    if (hit_now) begin
      found_slot_r <= chk_addr_r;
      found_ent_r  <= rd_data_r;
    end
    if (free_now) begin
      free_slot_r <= chk_addr_r;
    end
    if (state_r == S_FINISH && can_load) begin
      out_data_r <= res;
    end
  end

  `DVRT_ASSERT_IMP(a_pend_after_scan, rd_pend_r, $past(state_r) == S_SCAN, "read data without a scan read")
  `DVRT_ASSERT_IMP(a_no_rw_clash, mem_re && mem_we, wr_addr != rd_addr_r, "write hits the slot being read")
  `DVRT_ASSERT_NEXT(a_finish_holds, state_r == S_FINISH && out_valid_r && out_stall, state_r == S_FINISH, "result loaded over a pending one")
  `DVRT_ASSERT_IMP(a_fin_write_valid, fin_we, wr_entry.valid && wr_entry.refreshed, "advert writes a dead slot")

endmodule

// ===== tb/tb_distance_vector_route_table_core.sv =====
// self-checking bench for the distance-vector route table core
// keeps its own copy of the table and config, checks every result in order
// depends on dvrt_pkg and distance_vector_route_table_core
`timescale 1ns / 1ps
module tb_distance_vector_route_table_core;
  import dvrt_pkg::*;

  localparam int TABLE_SLOTS = 128;
  localparam int POOL_KEYS = 180;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  distance_vector_route_table_core #(.ENTRIES(TABLE_SLOTS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predicted node config and route table
  logic [63:0] node_key = '0;
  logic [31:0] node_addr = '0;
  logic [15:0] node_port = '0;
  logic rt_valid [TABLE_SLOTS];
  logic rt_fresh [TABLE_SLOTS];
  logic [63:0] rt_key [TABLE_SLOTS];
  logic [31:0] rt_addr [TABLE_SLOTS];
  logic [15:0] rt_port [TABLE_SLOTS];
  logic [7:0] rt_hops [TABLE_SLOTS];

  in_item_t pending [$];
  out_item_t route_expect [$];
  logic [63:0] key_pool [POOL_KEYS];

  int mismatch_count = 0;
  int sent_count = 0;
  int gap_cnt = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  bit pressure_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 12);
    return $urandom_range(20, 150);
  endfunction

  function automatic logic [7:0] bump_hops(input logic [7:0] h);
    return (h == 8'hff) ? 8'hff : h + 8'd1;
  endfunction

  function automatic int find_route(input logic [63:0] k);
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (rt_valid[i] && rt_key[i] == k) return i;
    end
    return -1;
  endfunction

  // works out the result of one accepted request and updates the table copy
  task automatic route_step(input in_item_t req);
    out_item_t res;
    int hit;
    int free_i;
    int removed;
    res = '0;
    case (req.kind)
      KIND_ADVERT: begin
        res.status = STAT_REFRESHED;
        if (req.dest_key != node_key) begin
          hit = find_route(req.dest_key);
          if (hit < 0) begin
            free_i = -1;
            for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
              if (!rt_valid[i]) free_i = i;
            end
            if (free_i < 0) begin
              res.status = STAT_FULL;
            end else begin
              rt_valid[free_i] = 1'b1;
              rt_fresh[free_i] = 1'b1;
              rt_key[free_i] = req.dest_key;
              rt_addr[free_i] = req.via_address;
              rt_port[free_i] = req.via_port;
              rt_hops[free_i] = bump_hops(req.advert_hops);
              res.status = STAT_INSERTED;
              res.slot = free_i[6:0];
              res.hops = rt_hops[free_i];
            end
          end else begin
            rt_fresh[hit] = 1'b1;
            if (rt_hops[hit] > req.advert_hops) begin
              rt_addr[hit] = req.via_address;
              rt_port[hit] = req.via_port;
              rt_hops[hit] = bump_hops(req.advert_hops);
              res.status = STAT_UPDATED;
            end
            res.slot = hit[6:0];
            res.hops = rt_hops[hit];
          end
        end
        route_expect.push_back(res);
      end
      KIND_SWEEP: begin
        removed = 0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (rt_valid[i] && !rt_fresh[i]) begin
            rt_valid[i] = 1'b0;
            removed++;
          end
          rt_fresh[i] = 1'b0;
        end
        res.status = STAT_SWEPT;
        res.removed_count = removed[7:0];
        route_expect.push_back(res);
      end
      KIND_LOOKUP: begin
        res.status = STAT_MISS;
        if (req.dest_key == node_key) begin
          res.status = STAT_HIT;
          res.hop_address = node_addr;
          res.hop_port = node_port;
        end else begin
          hit = find_route(req.dest_key);
          if (hit >= 0) begin
            res.status = STAT_HIT;
            res.slot = hit[6:0];
            res.hop_address = rt_addr[hit];
            res.hop_port = rt_port[hit];
            res.hops = rt_hops[hit];
          end
        end
        route_expect.push_back(res);
      end
      default: ;  // unused kind is dropped without a result
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_cnt = 0;
    end else begin
      if (in_valid && !in_stall) begin
        route_step(in_data);
        if (in_data.kind != KIND_UNUSED) sent_count++;
        gap_cnt = (calm || $urandom_range(0, 1) == 0) ? 0 : pause_len();
      end
      if (!in_valid || !in_stall) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure, with one long hold-off to fill the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (!pressure_done && sent_count >= 300) begin
        pressure_done = 1'b1;
        stall_left = 700;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 19) == 0) begin
        stall_left = pause_len();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (route_expect.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with no request pending: %p", $realtime, out_data);
      end else begin
        want = route_expect.pop_front();
        if (out_data.status !== want.status || out_data.slot !== want.slot ||
            out_data.hop_address !== want.hop_address ||
            out_data.hop_port !== want.hop_port || out_data.hops !== want.hops ||
            out_data.removed_count !== want.removed_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: route result wrong: want %p got %p", $realtime, want, out_data);
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    logic [63:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    // write lands here, then turn straight into a read-back
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== val) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: register %0d reads %h, want %h", $realtime, idx, got, val);
    end
  endtask

  task automatic set_node(input logic [63:0] k, input logic [31:0] a, input logic [15:0] p);
    write_reg(REG_OWN_KEY, k);
    write_reg(REG_OWN_ADDRESS, {32'd0, a});
    write_reg(REG_OWN_PORT, {48'd0, p});
    node_key = k;
    node_addr = a;
    node_port = p;
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || in_valid || route_expect.size() != 0) @(negedge clk);
    // a dropped unused-kind request may still be in flight
    repeat (TABLE_SLOTS + 10) @(posedge clk);
  endtask

  function automatic in_item_t make_req(input logic [1:0] kind, input logic [63:0] k,
                                        input logic [31:0] a, input logic [15:0] p,
                                        input logic [7:0] h);
    in_item_t it;
    it.kind = kind;
    it.dest_key = k;
    it.via_address = a;
    it.via_port = p;
    it.advert_hops = h;
    return it;
  endfunction

  function automatic logic [7:0] rand_hops();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    if (r == 2) return 8'd254;
    if (r < 5) return 8'($urandom);
    return 8'($urandom_range(0, 12));
  endfunction

  // one burst of adverts, lookups and unused-kind items closed by a sweep; fill bursts overflow the table
  task automatic push_round(input bit fill, inout int budget);
    int n;
    int r;
    logic [63:0] k;
    n = fill ? $urandom_range(220, 300) : $urandom_range(4, 50);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      k = key_pool[$urandom_range(0, POOL_KEYS - 1)];
      if ($urandom_range(0, 49) == 0) k = node_key;
      else if ($urandom_range(0, 49) == 0) k = {$urandom, $urandom};
      if (r < (fill ? 85 : 55)) begin
        pending.push_back(make_req(KIND_ADVERT, k, $urandom, 16'($urandom), rand_hops()));
        budget--;
      end else if (r < 97) begin
        pending.push_back(make_req(KIND_LOOKUP, k, $urandom, 16'($urandom), 8'($urandom)));
        budget--;
      end else begin
        pending.push_back(make_req(KIND_UNUSED, {$urandom, $urandom}, $urandom,
                                   16'($urandom), 8'($urandom)));
      end
    end
    pending.push_back(make_req(KIND_SWEEP, {$urandom, $urandom}, $urandom,
                               16'($urandom), 8'($urandom)));
    budget--;
  endtask

  task automatic run_random(input int count);
    int budget;
    bit first;
    budget = count;
    first = 1'b1;
    while (budget > 0) begin
      push_round(first || $urandom_range(0, 7) == 0, budget);
      first = 1'b0;
    end
  endtask

  initial begin
    logic [63:0] ones;
    logic [63:0] own;
    ones = '1;
    own = 64'h0123_4567_89ab_cdef;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      rt_valid[i] = 1'b0;
      rt_fresh[i] = 1'b0;
    end
    for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = {$urandom, $urandom};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    set_node(own, 32'hc0a8_0001, 16'd520);
    // directed: key extremes, hop saturation, better and worse adverts, own key
    pending.push_back(make_req(KIND_ADVERT, 64'd0, 32'd0, 16'd0, 8'd0));
    pending.push_back(make_req(KIND_ADVERT, ones, 32'hffff_ffff, 16'hffff, 8'd255));
    pending.push_back(make_req(KIND_ADVERT, ones, 32'h1234_5678, 16'h00ff, 8'd254));
    pending.push_back(make_req(KIND_ADVERT, ones, 32'h0, 16'h0, 8'd255));
    pending.push_back(make_req(KIND_ADVERT, ones, 32'h8000_0001, 16'h8001, 8'd7));
    pending.push_back(make_req(KIND_ADVERT, 64'd0, 32'hdead_beef, 16'h1111, 8'd200));
    pending.push_back(make_req(KIND_ADVERT, own, 32'hffff_ffff, 16'hffff, 8'd3));
    pending.push_back(make_req(KIND_LOOKUP, own, 32'd0, 16'd0, 8'd0));
    pending.push_back(make_req(KIND_LOOKUP, 64'd0, 32'd0, 16'd0, 8'd0));
    pending.push_back(make_req(KIND_LOOKUP, ones, 32'd0, 16'd0, 8'd0));
    pending.push_back(make_req(KIND_LOOKUP, 64'd5, 32'd0, 16'd0, 8'd0));
    pending.push_back(make_req(KIND_UNUSED, ones, 32'hffff_ffff, 16'hffff, 8'hff));
    pending.push_back(make_req(KIND_SWEEP, 64'd0, 32'd0, 16'd0, 8'd0));
    pending.push_back(make_req(KIND_ADVERT, 64'd0, 32'h0a0a_0a0a, 16'd80, 8'd3));
    pending.push_back(make_req(KIND_SWEEP, ones, 32'hffff_ffff, 16'hffff, 8'hff));
    pending.push_back(make_req(KIND_LOOKUP, ones, 32'd0, 16'd0, 8'd0));
    pending.push_back(make_req(KIND_ADVERT, 64'h5555_5555_5555_5555, 32'haaaa_aaaa,
                               16'h5555, 8'd128));
    pending.push_back(make_req(KIND_LOOKUP, 64'h5555_5555_5555_5555, 32'd0, 16'd0, 8'd0));
    pending.push_back(make_req(KIND_LOOKUP, 64'd0, 32'd0, 16'd0, 8'd0));
    pending.push_back(make_req(KIND_SWEEP, 64'd0, 32'd0, 16'd0, 8'd0));
    wait_idle();

    set_node(64'd0, 32'd0, 16'd0);
    run_random(700);
    wait_idle();

    calm = 1'b1;
    set_node(ones, 32'hffff_ffff, 16'hffff);
    run_random(500);
    wait_idle();

    calm = 1'b0;
    set_node(key_pool[3], $urandom, 16'($urandom));
    run_random(800);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
